@@ rtl/core/mff_pkg.sv @@
// Shared types, constants and the hash step for the message fragmenter framer.
package mff_pkg;

    // Default sizes
    localparam int MAX_PAYLOAD_DEF = 22;
    localparam int MAX_MESSAGE_DEF = 2048;

    // FNV-1a 32-bit constants
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    // Input opcodes
    localparam logic [1:0] KIND_NAME  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_DATA  = 2'd2;

    // Result status codes
    localparam logic [1:0] STATUS_DATA     = 2'd0;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd1;
    localparam logic [1:0] STATUS_TOO_MANY = 2'd2;

    // Header length in bytes; the payload byte follows at this index
    localparam int          HDR_LEN = 9;
    localparam logic [3:0]  HDR_IDX_LAST = 4'(HDR_LEN);

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [15:0] message_length;
        logic [15:0] message_id;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       message_end;
        logic [1:0] status;
    } out_t;

    // One unit of output work: a payload byte, optionally led by a header
    typedef struct packed {
        logic        header;
        logic [7:0]  frag_type;
        logic [31:0] sender_id;
        logic [15:0] msg_id;
        logic [7:0]  frag_total;
        logic [7:0]  frag_number;
        logic [7:0]  data;
        logic        frame_end;
        logic        message_end;
        logic [1:0]  status;
    } job_t;

    // Fold one byte into the running hash
    function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] x;
        logic [63:0] p;
        x = h ^ {24'd0, b};
        p = x * FNV_PRIME;
        return p[31:0];
    endfunction

endpackage

@@ rtl/core/mff_emit.sv @@
// Output serializer: one job slot in front of the byte emitter.
module mff_emit
    import mff_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic job_valid,
    input  job_t job,
    output logic job_ready,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_payload
);

    logic       pend_valid_reg;
    job_t       pend_job_reg;
    logic       cur_valid_reg;
    job_t       cur_job_reg;
    logic [3:0] idx_reg;
    logic       last;
    logic       cur_take;

    // Last transfer of the current job
    assign last     = !cur_job_reg.header || (idx_reg == HDR_IDX_LAST);
    assign cur_take = !cur_valid_reg || (m_ready && last);
    assign job_ready = !pend_valid_reg || cur_take;
    assign m_valid   = cur_valid_reg;

    // Advance the slot and the byte index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            cur_valid_reg  <= 1'b0;
            idx_reg        <= '0;
        end else begin
            if (cur_take) begin
                cur_valid_reg <= pend_valid_reg;
                cur_job_reg   <= pend_job_reg;
                idx_reg       <= '0;
            end else if (m_ready) begin
                idx_reg <= idx_reg + 4'd1;
            end
            if (job_ready) begin
                pend_valid_reg <= job_valid;
                if (job_valid) begin
                    pend_job_reg <= job;
                end
            end
        end
    end

    // Select the byte for this transfer
    always_comb begin
        m_payload.out_byte    = cur_job_reg.data;
        m_payload.frame_end   = 1'b0;
        m_payload.message_end = 1'b0;
        m_payload.status      = cur_job_reg.status;
        if (!cur_job_reg.header || idx_reg == HDR_IDX_LAST) begin
            m_payload.frame_end   = cur_job_reg.frame_end;
            m_payload.message_end = cur_job_reg.message_end;
        end else begin
            case (idx_reg)
                4'd0:    m_payload.out_byte = cur_job_reg.frag_type;
                4'd1:    m_payload.out_byte = cur_job_reg.sender_id[31:24];
                4'd2:    m_payload.out_byte = cur_job_reg.sender_id[23:16];
                4'd3:    m_payload.out_byte = cur_job_reg.sender_id[15:8];
                4'd4:    m_payload.out_byte = cur_job_reg.sender_id[7:0];
                4'd5:    m_payload.out_byte = cur_job_reg.msg_id[15:8];
                4'd6:    m_payload.out_byte = cur_job_reg.msg_id[7:0];
                4'd7:    m_payload.out_byte = cur_job_reg.frag_total;
                4'd8:    m_payload.out_byte = cur_job_reg.frag_number;
                default: m_payload.out_byte = cur_job_reg.data;
            endcase
        end
    end

endmodule

@@ rtl/core/message_fragmenter_framer.sv @@
// A result byte passes the job slot, then the emitter's current-job register, on its way to the output.
// Throughput: one input item per cycle while each produces at most one result byte and m_ready is high;
// a fragment's first payload byte holds the output for ten transfers (nine header bytes).
// The output port moves one byte per cycle while m_ready is high; it sets the sustained rate.
// Reset (aresetn low, synchronous): hash to FNV basis, message state and type to zero,
// all pending results dropped.
module message_fragmenter_framer
    import mff_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    parameter int MAX_MESSAGE = MAX_MESSAGE_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_t        s_payload,
    output logic       m_valid,
    input  logic       m_ready,
    output out_t       m_payload
);

    // Reciprocal for ceil(len / MAX_PAYLOAD), exact for all 17-bit numerators
    localparam logic [24:0] RECIP      = 25'((64'd1 << 24) / MAX_PAYLOAD + 1);
    localparam logic [16:0] FRAG_LIMIT = 17'(255 * MAX_PAYLOAD);
    localparam logic [16:0] MSG_LIMIT  = 17'(MAX_MESSAGE);
    localparam logic [8:0]  PAY_LIMIT  = 9'(MAX_PAYLOAD);

    logic [7:0]  frag_type_reg;
    logic [31:0] name_hash_reg;
    logic [31:0] sender_id_reg;
    logic [15:0] msg_id_reg;
    logic [7:0]  frag_total_reg;
    logic [7:0]  frag_number_reg;
    logic [7:0]  pay_pos_reg;
    logic [15:0] remaining_reg;

    logic        accept;
    logic        job_valid;
    job_t        job;
    logic [16:0] len_ext;
    logic [16:0] ceil_num;
    logic [41:0] quot_prod;
    logic [7:0]  quot;
    logic        too_long;
    logic        too_many;
    logic        fend;
    logic        mend;

    assign accept = s_valid && s_ready;

    // Fragment count and length checks for a message start
    assign len_ext   = {1'b0, s_payload.message_length};
    assign ceil_num  = len_ext + 17'(MAX_PAYLOAD - 1);
    assign quot_prod = 42'(ceil_num) * 42'(RECIP);
    assign quot      = quot_prod[31:24];
    assign too_long  = len_ext > MSG_LIMIT;
    assign too_many  = len_ext > FRAG_LIMIT;

    // End flags for a message byte
    assign mend = (remaining_reg == 16'd1);
    assign fend = mend || ({1'b0, pay_pos_reg} + 9'd1 >= PAY_LIMIT);

    // Build the output job for this item
    always_comb begin
        job_valid       = 1'b0;
        job.header      = (pay_pos_reg == 8'd0);
        job.frag_type   = frag_type_reg;
        job.sender_id   = sender_id_reg;
        job.msg_id      = msg_id_reg;
        job.frag_total  = frag_total_reg;
        job.frag_number = frag_number_reg;
        job.data        = s_payload.data_byte;
        job.frame_end   = fend;
        job.message_end = mend;
        job.status      = STATUS_DATA;
        unique case (s_payload.kind)
            KIND_START: begin
                job_valid       = too_long || too_many;
                job.header      = 1'b0;
                job.data        = 8'd0;
                job.frame_end   = 1'b0;
                job.message_end = 1'b0;
                job.status      = too_long ? STATUS_TOO_LONG : STATUS_TOO_MANY;
            end
            KIND_DATA: begin
                job_valid = (remaining_reg != 16'd0);
            end
            default: begin
                job_valid = 1'b0;
            end
        endcase
    end

    // Update message state on each input transfer, and the fragment type on a config write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frag_type_reg   <= '0;
            name_hash_reg   <= FNV_BASIS;
            sender_id_reg   <= '0;
            msg_id_reg      <= '0;
            frag_total_reg  <= '0;
            frag_number_reg <= '0;
            pay_pos_reg     <= '0;
            remaining_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                frag_type_reg <= cfg_wr_data;
            end
            if (accept) begin
                unique case (s_payload.kind)
                    KIND_NAME: begin
                        name_hash_reg <= fnv_step(name_hash_reg, s_payload.data_byte);
                    end
                    KIND_START: begin
                        sender_id_reg   <= name_hash_reg;
                        name_hash_reg   <= FNV_BASIS;
                        msg_id_reg      <= s_payload.message_id;
                        frag_number_reg <= '0;
                        pay_pos_reg     <= '0;
                        if (too_long || too_many) begin
                            frag_total_reg <= '0;
                            remaining_reg  <= '0;
                        end else begin
                            frag_total_reg <= quot;
                            remaining_reg  <= s_payload.message_length;
                        end
                    end
                    KIND_DATA: begin
                        if (remaining_reg != 16'd0) begin
                            remaining_reg <= remaining_reg - 16'd1;
                            if (fend) begin
                                pay_pos_reg     <= '0;
                                frag_number_reg <= frag_number_reg + 8'd1;
                            end else begin
                                pay_pos_reg <= pay_pos_reg + 8'd1;
                            end
                        end
                    end
                    default: begin
                        // drop
                    end
                endcase
            end
        end
    end

    mff_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (s_valid && job_valid),
        .job       (job),
        .job_ready (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

@@ rtl/core/mff_checker.sv @@
// Port checker for the message fragmenter framer, bound to the top level.
module mff_checker
    import mff_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic m_valid,
    input logic m_ready,
    input out_t m_payload
);

    // Hold a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_payload))
        else $error("result changed while stalled");

    // Error results carry no byte and no end flags
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.status != STATUS_DATA |->
            m_payload.out_byte == 8'd0 && !m_payload.frame_end && !m_payload.message_end)
        else $error("error result with data");

    // The last message byte also closes its fragment
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.message_end |-> m_payload.frame_end)
        else $error("message end without frame end");

endmodule

bind message_fragmenter_framer mff_checker u_mff_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);
